// ===== hdl/hbpam_pkg.sv =====
// ============================================================================
// hbpam_pkg
// Shared types, register offsets and the power-on image of the configuration
// space for the host bridge configuration block.
// ============================================================================
package hbpam_pkg;

    // Configuration space offsets
    localparam logic [7:0] ADDR_CMD_LO  = 8'h04;
    localparam logic [7:0] ADDR_CMD_HI  = 8'h05;
    localparam logic [7:0] ADDR_STS_LO  = 8'h06;
    localparam logic [7:0] ADDR_STS_HI  = 8'h07;
    localparam logic [7:0] ADDR_PAM0    = 8'h59;
    localparam logic [7:0] ADDR_PAM1    = 8'h5A;
    localparam logic [7:0] ADDR_PAM6    = 8'h5F;
    localparam logic [7:0] ADDR_SMRAM   = 8'h72;

    // Read-only windows
    localparam logic [7:0] ADDR_ID_LAST    = 8'h03;
    localparam logic [7:0] ADDR_CLASS_LO   = 8'h08;
    localparam logic [7:0] ADDR_CLASS_HI   = 8'h0C;
    localparam logic [7:0] ADDR_HDR_TYPE   = 8'h0E;
    localparam logic [7:0] ADDR_BAR_LO     = 8'h10;
    localparam logic [7:0] ADDR_BAR_HI     = 8'h4E;

    // Field masks
    localparam logic [7:0] CMD_WR_MASK   = 8'h02;
    localparam logic [7:0] CMD_FORCED    = 8'h04;
    localparam logic [7:0] STS_WR_MASK   = 8'h80;
    localparam logic [7:0] STS_FORCED    = 8'h02;
    localparam logic [7:0] SMRAM_MASK    = 8'h48;
    localparam logic [7:0] FUNC_ABSENT   = 8'hFF;

    // Segment codes, in 16 KB units
    localparam logic [5:0] SEG_SMRAM     = 6'd40;
    localparam logic [5:0] SEG_PAM_BASE  = 6'd48;
    localparam logic [5:0] SEG_BIOS      = 6'd60;
    localparam logic [3:0] LEN_16K       = 4'd1;
    localparam logic [3:0] LEN_64K       = 4'd4;
    localparam logic [3:0] LEN_128K      = 4'd8;

    // Access to the register file memory
    typedef struct packed {
        logic       rd_en;
        logic [7:0] rd_addr;
        logic       wr_en;
        logic [7:0] wr_addr;
        logic [7:0] wr_data;
    } t_rf_req;

    // Power-on value of each configuration byte
    function automatic logic [7:0] reset_value(input logic [7:0] addr);
        logic [7:0] v;
        v = 8'h00;
        case (addr)
            8'h00: v = 8'h86;
            8'h01: v = 8'h80;
            8'h02: v = 8'h30;
            8'h03: v = 8'h70;
            8'h04: v = 8'h06;
            8'h07: v = 8'h02;
            8'h0B: v = 8'h06;
            8'h52: v = 8'h42;
            8'h53: v = 8'h14;
            8'h56: v = 8'h52;
            8'h57: v = 8'h01;
            8'h60: v = 8'h02;
            8'h61: v = 8'h02;
            8'h62: v = 8'h02;
            8'h63: v = 8'h02;
            8'h64: v = 8'h02;
            8'h67: v = 8'h11;
            8'h69: v = 8'h03;
            8'h70: v = 8'h20;
            8'h72: v = 8'h02;
            8'h74: v = 8'h0E;
            8'h78: v = 8'h23;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

// ===== hdl/hbpam_regfile.sv =====
// ============================================================================
// hbpam_regfile
// 256 x 8 configuration byte store: synchronous memory with a registered read,
// plus a written flag per byte so unwritten bytes read their
// power-on value.
// ============================================================================
module hbpam_regfile
    import hbpam_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_rf_req    i_req,
    output logic [7:0] o_rd_data
);

    logic [7:0]   mem [256];
    logic [255:0] r_written;
    logic [7:0]   r_rd_q;
    logic [7:0]   r_rd_addr;
    logic         r_rd_hit;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_q    <= mem[i_req.rd_addr];
            r_rd_addr <= i_req.rd_addr;
            r_rd_hit  <= r_written[i_req.rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written <= '0;
        end else if (i_req.wr_en) begin
            r_written[i_req.wr_addr] <= 1'b1;
        end
    end

    // fall back to the power-on image until a byte is first written
    assign o_rd_data = r_rd_hit ? r_rd_q : reset_value(r_rd_addr);

endmodule

// ===== hdl/host_bridge_config_space_pam_core.sv =====
// ============================================================================
// host_bridge_config_space_pam_core
// Host bridge configuration space with PAM shadow and SMRAM map events.
// ============================================================================
// Sequence: memory read at the input transfer, then update and write-back in
//   S_LOOKUP, then results in S_EMIT; a write emits up to two map events first.
// A new access is taken only after the last result of the previous one has
//   drained, set by the read-modify-write of the configuration byte memory.
// Reset: synchronous, active low; restores the power-on register image
//   through per-byte written flags and clears the BIOS shadow flag.
// ============================================================================
module host_bridge_config_space_pam_core
    import hbpam_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    // request channel
    input  logic       i_valid,
    output logic       o_stall,
    input  logic       i_action,
    input  logic [2:0] i_func_number,
    input  logic [7:0] i_reg_addr,
    input  logic [7:0] i_write_data,
    // result channel
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_read_data,
    output logic       o_is_map_event,
    output logic [5:0] o_segment_start,
    output logic [3:0] o_segment_length,
    output logic       o_read_internal,
    output logic       o_write_internal,
    output logic       o_shadow_bios,
    output logic       o_last
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOKUP,
        S_EMIT
    } t_state;

    t_state      r_state;
    t_state      n_state;

    // captured request
    logic        r_action;
    logic [2:0]  r_func;
    logic [7:0]  r_addr;
    logic [7:0]  r_wdata;

    // result buffer: up to two map events then the completion
    logic [5:0]  r_ev_start [2];
    logic [3:0]  r_ev_len   [2];
    logic [1:0]  r_ev_attr  [2];
    logic [1:0]  r_nev;
    logic [1:0]  r_idx;
    logic [7:0]  r_rd_result;
    logic        r_shadow;

    t_rf_req     rf_req;
    logic [7:0]  rf_rd_data;

    // update logic, valid in S_LOOKUP
    logic        rd_only;
    logic        do_write;
    logic [7:0]  new_val;
    logic [7:0]  diff;
    logic [5:0]  ev_start [2];
    logic [3:0]  ev_len   [2];
    logic [1:0]  ev_attr  [2];
    logic [1:0]  nev;
    logic        n_shadow;
    logic [7:0]  rd_result;
    logic [2:0]  pam_off;
    logic [5:0]  pam_base;
    logic        out_is_event;

    hbpam_regfile u_regfile (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (rf_req),
        .o_rd_data (rf_rd_data)
    );

    // Hold off new requests until the current access has fully drained
    assign o_stall = (r_state != S_IDLE);
    assign o_valid = (r_state == S_EMIT);

    // Bytes that ignore writes, and every byte of an absent function
    always_comb begin
        rd_only = (r_func != 3'd0)
                || (r_addr <= ADDR_ID_LAST)
                || ((r_addr >= ADDR_CLASS_LO) && (r_addr <= ADDR_CLASS_HI))
                || (r_addr == ADDR_HDR_TYPE)
                || ((r_addr >= ADDR_BAR_LO) && (r_addr <= ADDR_BAR_HI));
    end

    // Modify step: mask the written byte and work out the map events
    always_comb begin
        diff     = rf_rd_data ^ r_wdata;
        new_val  = r_wdata;
        nev      = 2'd0;
        n_shadow = r_shadow;
        pam_off  = 3'(r_addr - ADDR_PAM1);
        pam_base = SEG_PAM_BASE + {2'b00, pam_off, 1'b0};
        for (int k = 0; k < 2; k++) begin
            ev_start[k] = '0;
            ev_len[k]   = '0;
            ev_attr[k]  = '0;
        end

        priority if (r_addr == ADDR_CMD_LO) begin
            new_val = (r_wdata & CMD_WR_MASK) | CMD_FORCED;
        end else if ((r_addr == ADDR_CMD_HI) || (r_addr == ADDR_STS_LO)) begin
            new_val = 8'h00;
        end else if (r_addr == ADDR_STS_HI) begin
            new_val = (r_wdata & STS_WR_MASK) | STS_FORCED;
        end else if (r_addr == ADDR_PAM0) begin
            // only the upper nibble covers the 64 KB BIOS segment
            if (diff[7:4] != 4'h0) begin
                ev_start[0] = SEG_BIOS;
                ev_len[0]   = LEN_64K;
                ev_attr[0]  = r_wdata[5:4];
                nev         = 2'd1;
                n_shadow    = r_wdata[4];
            end
        end else if ((r_addr >= ADDR_PAM1) && (r_addr <= ADDR_PAM6)) begin
            // lower 16 KB first, then upper; compact into the first free slot
            if (diff[3:0] != 4'h0) begin
                ev_start[0] = pam_base;
                ev_len[0]   = LEN_16K;
                ev_attr[0]  = r_wdata[1:0];
                nev         = 2'd1;
            end
            if (diff[7:4] != 4'h0) begin
                ev_start[nev[0]] = pam_base + 6'd1;
                ev_len[nev[0]]   = LEN_16K;
                ev_attr[nev[0]]  = r_wdata[5:4];
                nev              = nev + 2'd1;
            end
        end else if (r_addr == ADDR_SMRAM) begin
            if ((diff & SMRAM_MASK) != 8'h00) begin
                ev_start[0] = SEG_SMRAM;
                ev_len[0]   = LEN_128K;
                ev_attr[0]  = ((r_wdata & SMRAM_MASK) == SMRAM_MASK) ? 2'b11 : 2'b00;
                nev         = 2'd1;
            end
        end else begin
            new_val = r_wdata;
        end
    end

    assign do_write = r_action && !rd_only;

    always_comb begin
        if (r_action) begin
            rd_result = 8'h00;
        end else if (r_func != 3'd0) begin
            rd_result = FUNC_ABSENT;
        end else begin
            rd_result = rf_rd_data;
        end
    end

    // Read at the input transfer, write back in the lookup cycle. The stall
    // keeps the next read behind the write, so no forwarding is needed.
    always_comb begin
        rf_req.rd_en   = i_valid && (r_state == S_IDLE);
        rf_req.rd_addr = i_reg_addr;
        rf_req.wr_en   = (r_state == S_LOOKUP) && do_write;
        rf_req.wr_addr = r_addr;
        rf_req.wr_data = new_val;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (!i_stall && (r_idx == r_nev)) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_shadow <= 1'b0;
            r_idx    <= 2'd0;
            r_nev    <= 2'd0;
        end else begin
            r_state <= n_state;
            if (r_state == S_LOOKUP) begin
                r_idx <= 2'd0;
                if (do_write) begin
                    r_nev    <= nev;
                    r_shadow <= n_shadow;
                end else begin
                    r_nev <= 2'd0;
                end
            end else if ((r_state == S_EMIT) && !i_stall) begin
                // advance to the next buffered result
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    // Payload registers: request capture and result buffer
    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && i_valid) begin
            r_action <= i_action;
            r_func   <= i_func_number;
            r_addr   <= i_reg_addr;
            r_wdata  <= i_write_data;
        end
        if (r_state == S_LOOKUP) begin
            r_rd_result <= rd_result;
            for (int k = 0; k < 2; k++) begin
                r_ev_start[k] <= ev_start[k];
                r_ev_len[k]   <= ev_len[k];
                r_ev_attr[k]  <= ev_attr[k];
            end
        end
    end

    // Present map events first, then the completion with last set
    assign out_is_event = (r_idx < r_nev);

    always_comb begin
        if (out_is_event) begin
            o_read_data      = 8'h00;
            o_is_map_event   = 1'b1;
            o_segment_start  = r_ev_start[r_idx[0]];
            o_segment_length = r_ev_len[r_idx[0]];
            o_read_internal  = r_ev_attr[r_idx[0]][0];
            o_write_internal = r_ev_attr[r_idx[0]][1];
            o_last           = 1'b0;
        end else begin
            o_read_data      = r_rd_result;
            o_is_map_event   = 1'b0;
            o_segment_start  = 6'd0;
            o_segment_length = 4'd0;
            o_read_internal  = 1'b0;
            o_write_internal = 1'b0;
            o_last           = 1'b1;
        end
    end

    assign o_shadow_bios = r_shadow;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_event_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_is_map_event |-> !o_last)
        else $error("map event flagged as last result");

    a_more_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_last |=> o_valid)
        else $error("result sequence ended without a last result");

    a_event_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_is_map_event |->
            (o_segment_length == LEN_16K) || (o_segment_length == LEN_64K)
            || (o_segment_length == LEN_128K))
        else $error("map event with illegal segment length");

    a_no_write_on_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rf_req.wr_en |-> r_action && (r_func == 3'd0))
        else $error("register file written outside a function 0 write");

    a_event_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_nev <= 2'd2) && (r_idx <= r_nev))
        else $error("result index beyond buffered results");

endmodule

// ===== test/host_bridge_config_space_pam_core_tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// host_bridge_config_space_pam_core_tb
// Drives configuration reads and writes into the host bridge block and checks
// every completion and map event against a predictor of the register image,
// the PAM segment attributes, SMRAM mapping and the BIOS shadow flag.
// ============================================================================
module host_bridge_config_space_pam_core_tb;
    import hbpam_pkg::*;

    // Access type on the request channel
    localparam logic       ACT_READ  = 1'b0;
    localparam logic       ACT_WRITE = 1'b1;
    // The only function that exists; every other one reads as absent
    localparam logic [2:0] FUNC_HOST = 3'd0;
    // Cycles without any transfer before the run is declared hung
    localparam int         STALL_LIMIT = 2000;
    // Settling time after the last result
    localparam int         TAIL_CYCLES = 16;

    typedef struct packed {
        logic [7:0] read_data;
        logic       is_map_event;
        logic [5:0] seg_start;
        logic [3:0] seg_len;
        logic       rd_int;
        logic       wr_int;
        logic       shadow;
        logic       is_last;
    } t_access_result;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_stall;
    logic       i_action = ACT_READ;
    logic [2:0] i_func_number = FUNC_HOST;
    logic [7:0] i_reg_addr = 8'h00;
    logic [7:0] i_write_data = 8'h00;
    logic       o_valid;
    logic       i_stall = 1'b0;
    logic [7:0] o_read_data;
    logic       o_is_map_event;
    logic [5:0] o_segment_start;
    logic [3:0] o_segment_length;
    logic       o_read_internal;
    logic       o_write_internal;
    logic       o_shadow_bios;
    logic       o_last;

    // Predicted contents of the configuration space and the shadow flag
    logic [7:0]     cfg_image [256];
    logic           shadow_flag;
    // Results still owed by the block, oldest first
    t_access_result expected_results [$];

    int src_idle_pct  = 0;
    int sink_idle_pct = 0;
    int fail_count    = 0;
    int quiet_cycles  = 0;

    host_bridge_config_space_pam_core dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_action         (i_action),
        .i_func_number    (i_func_number),
        .i_reg_addr       (i_reg_addr),
        .i_write_data     (i_write_data),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_read_data      (o_read_data),
        .o_is_map_event   (o_is_map_event),
        .o_segment_start  (o_segment_start),
        .o_segment_length (o_segment_length),
        .o_read_internal  (o_read_internal),
        .o_write_internal (o_write_internal),
        .o_shadow_bios    (o_shadow_bios),
        .o_last           (o_last)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Queue one map event; the shadow field carries the flag after the access
    function automatic void push_map_event(logic [5:0] start, logic [3:0] len,
                                           logic rd, logic wr);
        t_access_result ev;
        ev              = '0;
        ev.is_map_event = 1'b1;
        ev.seg_start    = start;
        ev.seg_len      = len;
        ev.rd_int       = rd;
        ev.wr_int       = wr;
        ev.shadow       = shadow_flag;
        expected_results.push_back(ev);
    endfunction

    // Work out every result of one accepted access and update the image
    function automatic void predict_access(logic act, logic [2:0] fn,
                                           logic [7:0] addr, logic [7:0] data);
        t_access_result done;
        logic [7:0]     old_val;
        logic [7:0]     new_val;
        logic [5:0]     base;
        logic           read_only;
        done         = '0;
        done.is_last = 1'b1;
        read_only = (addr <= ADDR_ID_LAST) ||
                    (addr >= ADDR_CLASS_LO && addr <= ADDR_CLASS_HI) ||
                    (addr == ADDR_HDR_TYPE) ||
                    (addr >= ADDR_BAR_LO && addr <= ADDR_BAR_HI);
        if (act == ACT_READ) begin
            done.read_data = (fn != FUNC_HOST) ? FUNC_ABSENT : cfg_image[addr];
        end else if (fn == FUNC_HOST && !read_only) begin
            old_val = cfg_image[addr];
            new_val = data;
            case (addr)
                ADDR_CMD_LO: begin
                    new_val = (data & CMD_WR_MASK) | CMD_FORCED;
                end
                ADDR_CMD_HI, ADDR_STS_LO: begin
                    new_val = 8'h00;
                end
                ADDR_STS_HI: begin
                    new_val = (data & STS_WR_MASK) | STS_FORCED;
                end
                ADDR_PAM0: begin
                    // Only the upper nibble of PAM0 maps the BIOS segment
                    if (old_val[7:4] != data[7:4]) begin
                        shadow_flag = data[4];
                        push_map_event(SEG_BIOS, LEN_64K, data[4], data[5]);
                    end
                end
                ADDR_SMRAM: begin
                    if (((old_val ^ data) & SMRAM_MASK) != 8'h00) begin
                        push_map_event(SEG_SMRAM, LEN_128K,
                                       (data & SMRAM_MASK) == SMRAM_MASK,
                                       (data & SMRAM_MASK) == SMRAM_MASK);
                    end
                end
                default: begin
                    if (addr >= ADDR_PAM1 && addr <= ADDR_PAM6) begin
                        // Two 16 KB segments per byte, low nibble first
                        base = SEG_PAM_BASE + 6'((addr - ADDR_PAM1) * 2);
                        if (old_val[3:0] != data[3:0])
                            push_map_event(base, LEN_16K, data[0], data[1]);
                        if (old_val[7:4] != data[7:4])
                            push_map_event(base + 6'd1, LEN_16K, data[4], data[5]);
                    end
                end
            endcase
            cfg_image[addr] = new_val;
        end
        done.shadow = shadow_flag;
        expected_results.push_back(done);
    endfunction

    // ------------------------------------------------------------------------
    // Result checking and receiver stalls
    // ------------------------------------------------------------------------

    function automatic void check_field(string name, logic [7:0] want,
                                        logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin : result_check
        t_access_result want;
        // Sample the pre-edge values: a transfer happens at this edge
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_results.size() == 0) begin
                $error("result transfer with no access outstanding");
                fail_count++;
            end else begin
                want = expected_results.pop_front();
                check_field("read_data", want.read_data, o_read_data);
                check_field("is_map_event", 8'(want.is_map_event),
                            8'(o_is_map_event));
                check_field("segment_start", 8'(want.seg_start),
                            8'(o_segment_start));
                check_field("segment_length", 8'(want.seg_len),
                            8'(o_segment_length));
                check_field("read_internal", 8'(want.rd_int),
                            8'(o_read_internal));
                check_field("write_internal", 8'(want.wr_int),
                            8'(o_write_internal));
                check_field("shadow_bios", 8'(want.shadow), 8'(o_shadow_bios));
                check_field("last", 8'(want.is_last), 8'(o_last));
            end
        end
        i_stall <= (sink_idle_pct > 0) && ($urandom_range(99) < sink_idle_pct);
    end

    // Abort when neither channel has moved a transfer for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------

    // Present one access and hold it until the block takes it
    task automatic send_access(input logic act, input logic [2:0] fn,
                               input logic [7:0] addr, input logic [7:0] data);
        while ($urandom_range(99) < src_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_action      <= act;
        i_func_number <= fn;
        i_reg_addr    <= addr;
        i_write_data  <= data;
        do @(posedge i_clk); while (o_stall);
        predict_access(act, fn, addr, data);
    endtask

    // Drop valid and hold off until every owed result has arrived
    task automatic wait_drained();
        i_valid <= 1'b0;
        while (expected_results.size() != 0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic test_reset_image();
        send_access(ACT_READ, FUNC_HOST, 8'h00, 8'h00);
        send_access(ACT_READ, FUNC_HOST, ADDR_CMD_LO, 8'hFF);
        send_access(ACT_READ, FUNC_HOST, ADDR_SMRAM, 8'h00);
        send_access(ACT_READ, FUNC_HOST, 8'hFF, 8'h00);
        // absent function reads all ones
        send_access(ACT_READ, 3'd7, 8'h00, 8'h00);
    endtask

    task automatic test_read_only_bytes();
        send_access(ACT_WRITE, FUNC_HOST, 8'h00, 8'hFF);
        send_access(ACT_WRITE, FUNC_HOST, ADDR_HDR_TYPE, 8'hFF);
        send_access(ACT_WRITE, FUNC_HOST, ADDR_BAR_LO, 8'hFF);
        send_access(ACT_WRITE, FUNC_HOST, ADDR_BAR_HI, 8'hFF);
        // a write to an absent function must leave the image alone
        send_access(ACT_WRITE, 3'd3, 8'h80, 8'hFF);
        send_access(ACT_READ, FUNC_HOST, ADDR_BAR_HI, 8'h00);
        send_access(ACT_READ, FUNC_HOST, 8'h80, 8'h00);
    endtask

    task automatic test_command_status();
        send_access(ACT_WRITE, FUNC_HOST, ADDR_CMD_LO, 8'hFF);
        send_access(ACT_WRITE, FUNC_HOST, ADDR_CMD_HI, 8'hFF);
        send_access(ACT_WRITE, FUNC_HOST, ADDR_STS_LO, 8'hFF);
        send_access(ACT_WRITE, FUNC_HOST, ADDR_STS_HI, 8'hFF);
        send_access(ACT_READ, FUNC_HOST, ADDR_CMD_LO, 8'h00);
        send_access(ACT_READ, FUNC_HOST, ADDR_STS_HI, 8'h00);
    endtask

    task automatic test_map_events();
        // BIOS segment on, shadow flag set
        send_access(ACT_WRITE, FUNC_HOST, ADDR_PAM0, 8'h30);
        // low nibble of PAM0 gives no event
        send_access(ACT_WRITE, FUNC_HOST, ADDR_PAM0, 8'h33);
        // both nibbles change: two events, then the completion
        send_access(ACT_WRITE, FUNC_HOST, ADDR_PAM6, 8'hFF);
        send_access(ACT_WRITE, FUNC_HOST, ADDR_SMRAM, SMRAM_MASK);
        send_access(ACT_WRITE, FUNC_HOST, ADDR_SMRAM, 8'h40);
        // unchanged SMRAM bits give no event
        send_access(ACT_WRITE, FUNC_HOST, ADDR_SMRAM, 8'h40);
        send_access(ACT_WRITE, FUNC_HOST, ADDR_PAM0, 8'h00);
    endtask

    // PAM and SMRAM writes, the largest share, to keep the map logic busy, plus reads and
    // fully random accesses over every field
    task automatic test_random_accesses(input int count);
        int         sel;
        logic       act;
        logic [2:0] fn;
        logic [7:0] addr;
        logic [7:0] data;
        repeat (count) begin
            sel  = $urandom_range(99);
            act  = ACT_WRITE;
            fn   = FUNC_HOST;
            addr = 8'($urandom_range(255));
            data = 8'($urandom_range(255));
            if (sel < 35) begin
                addr = ADDR_PAM0 + 8'($urandom_range(6));
            end else if (sel < 45) begin
                addr = ADDR_SMRAM;
            end else if (sel < 65) begin
                act = ACT_READ;
            end else if (sel < 75) begin
                act = 1'($urandom_range(1));
                fn  = 3'($urandom_range(7, 1));
            end else begin
                act = 1'($urandom_range(1));
                fn  = 3'($urandom_range(7));
            end
            send_access(act, fn, addr, data);
        end
    endtask

    initial begin
        // Power-on image of the configuration space
        for (int a = 0; a < 256; a++) cfg_image[a] = 8'h00;
        cfg_image[8'h00] = 8'h86; cfg_image[8'h01] = 8'h80;
        cfg_image[8'h02] = 8'h30; cfg_image[8'h03] = 8'h70;
        cfg_image[8'h04] = 8'h06; cfg_image[8'h07] = 8'h02;
        cfg_image[8'h0B] = 8'h06;
        cfg_image[8'h52] = 8'h42; cfg_image[8'h53] = 8'h14;
        cfg_image[8'h56] = 8'h52; cfg_image[8'h57] = 8'h01;
        cfg_image[8'h60] = 8'h02; cfg_image[8'h61] = 8'h02;
        cfg_image[8'h62] = 8'h02; cfg_image[8'h63] = 8'h02;
        cfg_image[8'h64] = 8'h02; cfg_image[8'h67] = 8'h11;
        cfg_image[8'h69] = 8'h03; cfg_image[8'h70] = 8'h20;
        cfg_image[8'h72] = 8'h02; cfg_image[8'h74] = 8'h0E;
        cfg_image[8'h78] = 8'h23;
        shadow_flag = 1'b0;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: sender idles lightly, receiver heavily
        src_idle_pct  = 24;
        sink_idle_pct = 58;
        test_reset_image();
        test_read_only_bytes();
        test_command_status();
        test_map_events();

        test_random_accesses(130);
        // Hold the sender until the block has emptied out
        wait_drained();

        src_idle_pct  = 58;
        sink_idle_pct = 24;
        test_random_accesses(130);
        wait_drained();

        // Back-to-back transfers with no idling on either side
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        test_random_accesses(140);
        wait_drained();

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && expected_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
